// File: rtl/trr_pkg.sv
package trr_pkg;

	localparam int DATA_W      = 32;
	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = 7;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int FRAC_W      = 16;
	localparam int IN_DATA_W   = 136;
	localparam int CFG_IDX_W   = 3;

	localparam logic [DATA_W-1:0] DMAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_MODE_TABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAS_FLUID      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_CPDUST     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CUBIC     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_QUARTIC   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SCALE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT    = 3'd7;

	localparam logic CMD_COMPUTE = 1'b0;
	localparam logic CMD_LOAD    = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SAT      = 2'd1;
	localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TMUL, ST_TCHK, ST_TDIV, ST_POST, ST_RD0W, ST_RDNW,
		ST_SRCH, ST_SCMP, ST_IMUL, ST_IDIV0, ST_IDIV, ST_SMUL, ST_SSAT,
		ST_ASQ, ST_ASAT1, ST_ACUB, ST_ASAT2, ST_ACOEF, ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] num;
		logic [DATA_W-1:0] den;
	} div_req_t;

endpackage

// File: rtl/trr_div.sv
module trr_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trr_pkg::div_req_t    req,
	output logic                 done,
	output logic [trr_pkg::DATA_W-1:0] quot
);

	localparam int STEP_W = $clog2(trr_pkg::DATA_W);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           cnt_q;
	logic [trr_pkg::DATA_W-1:0]  rem_q;
	logic [trr_pkg::DATA_W-1:0]  quo_q;
	logic [trr_pkg::DATA_W-1:0]  den_q;
	logic [trr_pkg::DATA_W:0]    trial;
	logic                        ge;

	// one quotient bit per cycle; the upper half of the dividend is below the divisor
	assign trial = {rem_q, quo_q[trr_pkg::DATA_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[trr_pkg::PROD_W-1:trr_pkg::DATA_W];
			quo_q <= req.num[trr_pkg::DATA_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? trial[trr_pkg::DATA_W-1:0] - den_q : trial[trr_pkg::DATA_W-1:0];
			quo_q <= {quo_q[trr_pkg::DATA_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: rtl/thermal_relaxation_rate_core.sv
// channel  dir  tdata                                       tuser
// s_axis   in   energy, density, entry_index,               cmd
//               entry_temperature, entry_factor
// m_axis   out  rate                                        status
// cfg      in   cfg_we / cfg_index / cfg_data, no read-back
// One word at a time: no new word is accepted until the last one is finished.
// A load word is written to the table RAM as it is accepted. A compute word may use the
// 32-step serial divider (at most once for T and once more for interpolation) and, in
// table mode, a binary search of the table RAM. Gas or zero-density words go straight to the output.
// Reset clears control and config only; datapath and table RAM hold garbage until written.
// A result waiting in the output register stalls only the final hand-over of the next word.
module thermal_relaxation_rate_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// energy[31:0], density[63:32], entry_index[69:64],
	// entry_temperature[101:70], entry_factor[133:102], zero pad
	input  logic [trr_pkg::IN_DATA_W-1:0]   s_tdata,
	// cmd[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// rate[31:0]
	output logic [trr_pkg::DATA_W-1:0]      m_tdata,
	// status[1:0]
	output logic [1:0]                      m_tuser,
	input  logic                            cfg_we,
	input  logic [trr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [trr_pkg::DATA_W-1:0]      cfg_data
);

	localparam int DW = trr_pkg::DATA_W;
	localparam int AW = trr_pkg::ADDR_W;

	trr_pkg::state_t state_q, state_d;

	logic                         mode_table_q, gas_fluid_q;
	logic [DW-1:0]                inv_cpdust_q, temp_threshold_q, coef_cubic_q;
	logic [DW-1:0]                coef_quartic_q, table_scale_q;
	logic [trr_pkg::COUNT_W-1:0]  table_count_q;

	logic [2*DW-1:0]  mem [trr_pkg::TABLE_DEPTH];
	logic [2*DW-1:0]  rd_q;
	logic [AW-1:0]    rd_addr;
	logic [DW-1:0]    rd_temp, rd_fac;

	logic [DW-1:0]    e_q, d_q, t_q, p_q, f_q, t0_q, f0_q, t1_q, f1_q, res_q;
	logic [AW-1:0]    lo_q, hi_q, mid_q, mid, last_idx;
	logic             big_q, cub_q, up_q, ov_q;
	logic [1:0]       st_q;
	logic [2*DW-1:0]  prod_q;
	logic [DW-1:0]    mul_a, mul_b;
	logic             mul_en;
	logic [DW-1:0]    sat_p;
	logic             sat_ovf;
	logic [DW-1:0]    coef_sel;

	trr_pkg::div_req_t div_req;
	logic              div_done;
	logic [DW-1:0]     div_quot;

	logic             in_acc, out_load;
	logic [DW-1:0]    in_energy, in_density, in_temp, in_fac;
	logic [AW-1:0]    in_idx;

	assign in_energy  = s_tdata[31:0];
	assign in_density = s_tdata[63:32];
	assign in_idx     = s_tdata[69:64];
	assign in_temp    = s_tdata[101:70];
	assign in_fac     = s_tdata[133:102];

	assign s_tready = state_q == trr_pkg::ST_IDLE;
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = state_q == trr_pkg::ST_OUT && (!ov_q || m_tready);

	assign rd_temp = rd_q[DW-1:0];
	assign rd_fac  = rd_q[2*DW-1:DW];

	always_comb begin
		if (table_count_q < 7'd2)
			last_idx = AW'(1);
		else if (table_count_q > 7'(trr_pkg::TABLE_DEPTH))
			last_idx = AW'(trr_pkg::TABLE_DEPTH - 1);
		else
			last_idx = AW'(table_count_q - 7'd1);
	end

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign sat_ovf  = prod_q[2*DW-1:DW+trr_pkg::FRAC_W] != '0;
	assign sat_p    = sat_ovf ? trr_pkg::DMAX : prod_q[DW+trr_pkg::FRAC_W-1:trr_pkg::FRAC_W];
	assign coef_sel = cub_q ? coef_cubic_q : coef_quartic_q;

	trr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_table_q     <= 1'b0;
			gas_fluid_q      <= 1'b0;
			inv_cpdust_q     <= 32'h0001_0000;
			temp_threshold_q <= 32'h0001_0000;
			coef_cubic_q     <= '0;
			coef_quartic_q   <= '0;
			table_scale_q    <= 32'h0001_0000;
			table_count_q    <= 7'(trr_pkg::TABLE_DEPTH);
		end else if (cfg_we) begin
			case (cfg_index)
				trr_pkg::REG_MODE_TABLE:     mode_table_q     <= cfg_data[0];
				trr_pkg::REG_GAS_FLUID:      gas_fluid_q      <= cfg_data[0];
				trr_pkg::REG_INV_CPDUST:     inv_cpdust_q     <= cfg_data;
				trr_pkg::REG_TEMP_THRESHOLD: temp_threshold_q <= cfg_data;
				trr_pkg::REG_COEF_CUBIC:     coef_cubic_q     <= cfg_data;
				trr_pkg::REG_COEF_QUARTIC:   coef_quartic_q   <= cfg_data;
				trr_pkg::REG_TABLE_SCALE:    table_scale_q    <= cfg_data;
				trr_pkg::REG_TABLE_COUNT:    table_count_q    <= cfg_data[trr_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// table RAM: one write, one registered read
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == trr_pkg::CMD_LOAD)
			mem[in_idx] <= {in_fac, in_temp};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trr_pkg::ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= res_q;
			m_tuser <= st_q;
		end
	end

	assign m_tvalid = ov_q;

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		mul_a   = '0;
		mul_b   = '0;
		mul_en  = 1'b0;
		div_req = '{start: 1'b0, num: prod_q, den: d_q};
		case (state_q)
			trr_pkg::ST_IDLE: begin
				if (in_acc && s_tuser == trr_pkg::CMD_COMPUTE) begin
					if (gas_fluid_q || in_density == '0)
						state_d = trr_pkg::ST_OUT;
					else
						state_d = trr_pkg::ST_TMUL;
				end
			end
			trr_pkg::ST_TMUL: begin
				mul_a = e_q; mul_b = inv_cpdust_q; mul_en = 1'b1;
				state_d = trr_pkg::ST_TCHK;
			end
			trr_pkg::ST_TCHK: begin
				if (prod_q[2*DW-1:DW] >= d_q) begin
					state_d = trr_pkg::ST_POST;
				end else begin
					div_req.start = 1'b1;
					state_d = trr_pkg::ST_TDIV;
				end
			end
			trr_pkg::ST_TDIV: if (div_done) state_d = trr_pkg::ST_POST;
			trr_pkg::ST_POST: begin
				rd_addr = '0;
				state_d = mode_table_q ? trr_pkg::ST_RD0W : trr_pkg::ST_ASQ;
			end
			trr_pkg::ST_RD0W: begin
				rd_addr = last_idx;
				state_d = (t_q <= rd_temp) ? trr_pkg::ST_SMUL : trr_pkg::ST_RDNW;
			end
			trr_pkg::ST_RDNW: state_d = (t_q >= rd_temp) ? trr_pkg::ST_SMUL : trr_pkg::ST_SRCH;
			trr_pkg::ST_SRCH: begin
				rd_addr = mid;
				state_d = (hi_q - lo_q > AW'(1)) ? trr_pkg::ST_SCMP : trr_pkg::ST_IMUL;
			end
			trr_pkg::ST_SCMP: state_d = trr_pkg::ST_SRCH;
			trr_pkg::ST_IMUL: begin
				mul_a  = (f1_q >= f0_q) ? f1_q - f0_q : f0_q - f1_q;
				mul_b  = t_q - t0_q;
				mul_en = 1'b1;
				state_d = trr_pkg::ST_IDIV0;
			end
			trr_pkg::ST_IDIV0: begin
				div_req.start = 1'b1;
				div_req.den   = t1_q - t0_q;
				state_d = trr_pkg::ST_IDIV;
			end
			trr_pkg::ST_IDIV: if (div_done) state_d = trr_pkg::ST_SMUL;
			trr_pkg::ST_SMUL: begin
				mul_a = f_q; mul_b = table_scale_q; mul_en = 1'b1;
				state_d = trr_pkg::ST_SSAT;
			end
			trr_pkg::ST_SSAT: state_d = trr_pkg::ST_OUT;
			trr_pkg::ST_ASQ: begin
				mul_a = t_q; mul_b = t_q; mul_en = 1'b1;
				state_d = trr_pkg::ST_ASAT1;
			end
			trr_pkg::ST_ASAT1: state_d = trr_pkg::ST_ACUB;
			trr_pkg::ST_ACUB: begin
				mul_a = p_q; mul_b = cub_q ? t_q : p_q; mul_en = 1'b1;
				state_d = trr_pkg::ST_ASAT2;
			end
			trr_pkg::ST_ASAT2: state_d = trr_pkg::ST_ACOEF;
			trr_pkg::ST_ACOEF: begin
				if (coef_sel == '0 || big_q) begin
					state_d = trr_pkg::ST_OUT;
				end else begin
					mul_a = coef_sel; mul_b = p_q; mul_en = 1'b1;
					state_d = trr_pkg::ST_SSAT;
				end
			end
			trr_pkg::ST_OUT: if (!ov_q || m_tready) state_d = trr_pkg::ST_IDLE;
			default: state_d = trr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= {{DW{1'b0}}, mul_a} * {{DW{1'b0}}, mul_b};
		case (state_q)
			trr_pkg::ST_IDLE: begin
				e_q   <= in_energy;
				d_q   <= in_density;
				res_q <= '0;
				st_q  <= (!gas_fluid_q && in_density == '0) ? trr_pkg::STATUS_ZERO_DEN
				                                            : trr_pkg::STATUS_OK;
				big_q <= 1'b0;
			end
			trr_pkg::ST_TCHK: begin
				if (prod_q[2*DW-1:DW] >= d_q) begin
					t_q   <= trr_pkg::DMAX;
					big_q <= 1'b1;
				end
			end
			trr_pkg::ST_TDIV: if (div_done) t_q <= div_quot;
			trr_pkg::ST_RD0W: begin
				t0_q <= rd_temp; f0_q <= rd_fac; f_q <= rd_fac;
			end
			trr_pkg::ST_RDNW: begin
				t1_q <= rd_temp; f1_q <= rd_fac; f_q <= rd_fac;
				lo_q <= '0; hi_q <= last_idx;
			end
			trr_pkg::ST_SRCH: mid_q <= mid;
			trr_pkg::ST_SCMP: begin
				if (t_q >= rd_temp) begin
					lo_q <= mid_q; t0_q <= rd_temp; f0_q <= rd_fac;
				end else begin
					hi_q <= mid_q; t1_q <= rd_temp; f1_q <= rd_fac;
				end
			end
			trr_pkg::ST_IMUL: up_q <= f1_q >= f0_q;
			trr_pkg::ST_IDIV: if (div_done) f_q <= up_q ? f0_q + div_quot : f0_q - div_quot;
			trr_pkg::ST_SSAT: begin
				res_q <= sat_p;
				st_q  <= sat_ovf ? trr_pkg::STATUS_SAT : trr_pkg::STATUS_OK;
			end
			trr_pkg::ST_ASAT1: begin
				p_q   <= sat_p;
				big_q <= big_q | sat_ovf;
				cub_q <= t_q >= temp_threshold_q;
			end
			trr_pkg::ST_ASAT2: begin
				p_q   <= sat_p;
				big_q <= big_q | sat_ovf;
			end
			trr_pkg::ST_ACOEF: begin
				// zero coefficient wins over power overflow
				if (coef_sel == '0) begin
					res_q <= '0; st_q <= trr_pkg::STATUS_OK;
				end else if (big_q) begin
					res_q <= trr_pkg::DMAX; st_q <= trr_pkg::STATUS_SAT;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/trr_check.sv
module trr_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [trr_pkg::DATA_W-1:0]    m_tdata,
	input logic [1:0]                    m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word dropped or changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == trr_pkg::STATUS_OK || m_tuser == trr_pkg::STATUS_SAT
		             || m_tuser == trr_pkg::STATUS_ZERO_DEN)
		else $error("undefined status code");

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == trr_pkg::STATUS_ZERO_DEN |-> m_tdata == '0)
		else $error("zero density with non-zero rate");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == trr_pkg::STATUS_SAT |-> m_tdata == trr_pkg::DMAX)
		else $error("saturation flag without full-scale rate");

	// an accepted compute word closes the input; only the state right after acceptance is checked
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == trr_pkg::CMD_COMPUTE |=> !s_tready)
		else $error("input accepted while a compute word is in flight");

endmodule

bind thermal_relaxation_rate_core trr_check u_trr_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
